// ----- rtl/dq_pkg.sv -----
// Shared constants, types and helper functions of the double-ended queue.
package dq_pkg;

	// Queue geometry.
	localparam int DEPTH = 16;
	localparam int VALUE_BITS = 32;
	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam int PORT_BITS = 32;

	// Command codes.
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_BACK   = 3'd3;
	localparam logic [2:0] CMD_CLEAR      = 3'd4;

	// Status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [CNT_BITS-1:0] count_t;

	// Operation that the whole row of cells performs together.
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_SHIFT_IN,
		OP_SHIFT_OUT,
		OP_FILL_BACK,
		OP_DROP_BACK,
		OP_CLEAR
	} cell_op_t;

	// Control broadcast to every cell.
	typedef struct packed {
		cell_op_t op;
		value_t   data;
	} cell_ctrl_t;

	// Bring a port word to the stored width, zero-extending if wider.
	function automatic value_t to_store(input logic [PORT_BITS-1:0] d);
		value_t r;
		r = '0;
		for (int i = 0; i < VALUE_BITS; i++) begin
			if (i < PORT_BITS)
				r[i] = d[i];
		end
		return r;
	endfunction

	// Bring a stored word to the port width, keeping its low bits.
	function automatic logic [PORT_BITS-1:0] to_port(input value_t v);
		logic [PORT_BITS-1:0] r;
		r = '0;
		for (int i = 0; i < PORT_BITS; i++) begin
			if (i < VALUE_BITS)
				r[i] = v[i];
		end
		return r;
	endfunction

endpackage

// ----- rtl/double_ended_queue.sv -----
// The result is registered: it appears in the output register in the cycle after its command beat.
// Throughput: one command per cycle while the output side takes results; the row of
// cells shifts, fills or drops all at once, so that row update sets the rate.
// Reset clears every occupied flag, the count and the output valid at once;
// stored values are undefined until pushed.
module double_ended_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   cmd,
	input  logic signed [31:0]           data_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [31:0]           popped_value,
	output logic                         popped_valid,
	output logic [1:0]                   status,
	output logic signed [31:0]           front_value,
	output logic signed [31:0]           back_value,
	output logic                         is_empty,
	output logic                         is_full,
	output logic [dq_pkg::CNT_BITS-1:0]  item_count
);
	import dq_pkg::*;

	logic       accept;
	cell_ctrl_t ctrl;
	value_t     val_w [DEPTH];
	logic       occ_w [DEPTH];
	logic       last_w [DEPTH];
	value_t     nval_w [DEPTH];
	logic       nocc_w [DEPTH];

	logic       full_now;
	logic       empty_now;
	logic [1:0] status_d;
	logic       pvalid_d;
	value_t     popped_d;
	value_t     back_now;
	value_t     back_nxt;
	count_t     count_q;
	count_t     count_d;

	logic                   out_valid_q;
	logic [PORT_BITS-1:0]   popped_q;
	logic                   pvalid_q;
	logic [1:0]             status_q;
	logic [PORT_BITS-1:0]   front_q;
	logic [PORT_BITS-1:0]   back_q;
	logic                   empty_q;
	logic                   full_q;
	count_t                 count_out_q;

	// A new beat is taken unless a finished result is held back.
	assign in_stall = out_valid_q && out_stall;
	assign accept = in_valid && !in_stall;

	assign full_now = occ_w[DEPTH-1];
	assign empty_now = !occ_w[0];

	// Back element now and after the update, picked by the last-cell flags.
	always_comb begin
		back_now = '0;
		back_nxt = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (last_w[i])
				back_now = back_now | val_w[i];
			if (nocc_w[i] && (i == DEPTH - 1 || !nocc_w[(i + 1) % DEPTH]))
				back_nxt = back_nxt | nval_w[i];
		end
	end

	// Command decode into a row operation, status and count update.
	always_comb begin
		ctrl.op = OP_HOLD;
		ctrl.data = to_store(data_in);
		status_d = ST_OK;
		pvalid_d = 1'b0;
		popped_d = '0;
		count_d = count_q;
		if (accept) begin
			unique case (cmd)
				CMD_PUSH_BACK: begin
					if (full_now) begin
						status_d = ST_OVERFLOW;
					end else begin
						ctrl.op = OP_FILL_BACK;
						count_d = count_q + count_t'(1);
					end
				end
				CMD_PUSH_FRONT: begin
					if (full_now) begin
						status_d = ST_OVERFLOW;
					end else begin
						ctrl.op = OP_SHIFT_IN;
						count_d = count_q + count_t'(1);
					end
				end
				CMD_POP_FRONT: begin
					if (empty_now) begin
						status_d = ST_UNDERFLOW;
					end else begin
						ctrl.op = OP_SHIFT_OUT;
						pvalid_d = 1'b1;
						popped_d = val_w[0];
						count_d = count_q - count_t'(1);
					end
				end
				CMD_POP_BACK: begin
					if (empty_now) begin
						status_d = ST_UNDERFLOW;
					end else begin
						ctrl.op = OP_DROP_BACK;
						pvalid_d = 1'b1;
						popped_d = back_now;
						count_d = count_q - count_t'(1);
					end
				end
				CMD_CLEAR: begin
					ctrl.op = OP_CLEAR;
					count_d = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// The row of cells; the first cell sees the pushed word on its left.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		value_t lv;
		logic   lo;
		value_t rv;
		logic   ro;

		if (g == 0) begin : g_first
			assign lv = ctrl.data;
			assign lo = 1'b1;
		end else begin : g_inner_l
			assign lv = val_w[g-1];
			assign lo = occ_w[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign rv = '0;
			assign ro = 1'b0;
		end else begin : g_inner_r
			assign rv = val_w[g+1];
			assign ro = occ_w[g+1];
		end

		dq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.left_val  (lv),
			.left_occ  (lo),
			.right_val (rv),
			.right_occ (ro),
			.val       (val_w[g]),
			.occ       (occ_w[g]),
			.last      (last_w[g]),
			.nxt_val   (nval_w[g]),
			.nxt_occ   (nocc_w[g])
		);
	end

	// Control registers: element count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Result register, loaded with the state as it stands after the command.
	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q <= to_port(popped_d);
			pvalid_q <= pvalid_d;
			status_q <= status_d;
			front_q <= nocc_w[0] ? to_port(nval_w[0]) : '0;
			back_q <= to_port(back_nxt);
			empty_q <= !nocc_w[0];
			full_q <= nocc_w[DEPTH-1];
			count_out_q <= count_d;
		end
	end

	assign out_valid = out_valid_q;
	assign popped_value = popped_q;
	assign popped_valid = pvalid_q;
	assign status = status_q;
	assign front_value = front_q;
	assign back_value = back_q;
	assign is_empty = empty_q;
	assign is_full = full_q;
	assign item_count = count_out_q;

endmodule

// ----- rtl/dq_cell.sv -----
// One storage cell of the queue row: a value, an occupied flag and neighbor moves.
module dq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  dq_pkg::cell_ctrl_t ctrl,
	input  dq_pkg::value_t     left_val,
	input  logic               left_occ,
	input  dq_pkg::value_t     right_val,
	input  logic               right_occ,
	output dq_pkg::value_t     val,
	output logic               occ,
	output logic               last,
	output dq_pkg::value_t     nxt_val,
	output logic               nxt_occ
);
	import dq_pkg::*;

	value_t val_q;
	logic   occ_q;

	// The cell holds the back element when it is occupied and its right neighbor is not.
	assign last = occ_q && !right_occ;

	// Next contents follow the row operation.
	always_comb begin
		nxt_val = val_q;
		nxt_occ = occ_q;
		case (ctrl.op)
			OP_SHIFT_IN: begin
				nxt_val = left_val;
				nxt_occ = left_occ;
			end
			OP_SHIFT_OUT: begin
				nxt_val = right_val;
				nxt_occ = right_occ;
			end
			OP_FILL_BACK: begin
				if (!occ_q && left_occ) begin
					nxt_val = ctrl.data;
					nxt_occ = 1'b1;
				end
			end
			OP_DROP_BACK: begin
				if (last)
					nxt_occ = 1'b0;
			end
			OP_CLEAR: begin
				nxt_occ = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Occupied flag is control state and resets; the value does not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			occ_q <= 1'b0;
		else
			occ_q <= nxt_occ;
	end

	always_ff @(posedge clk) begin
		val_q <= nxt_val;
	end

	assign val = val_q;
	assign occ = occ_q;

endmodule
